[sv/dqqp_pkg.sv]
// Shared types, constants and helpers for the DNS query question parser.
package dqqp_pkg;

	localparam int unsigned MAX_DATAGRAM_BYTES = 65535;
	localparam logic [15:0] MAX_POS = 16'(MAX_DATAGRAM_BYTES);
	localparam logic [15:0] HDR_FLAGS_POS = 16'd2;
	localparam logic [15:0] HDR_QDCNT_HI_POS = 16'd4;
	localparam logic [15:0] HDR_QDCNT_LO_POS = 16'd5;
	localparam logic [15:0] HDR_LAST_POS = 16'd11;
	localparam logic [15:0] HDR_BYTES = 16'd12;
	localparam logic [7:0] QR_MASK = 8'h80;
	localparam logic [3:0] OPCODE_MASK = 4'hF;
	localparam logic [7:0] PTR_MASK = 8'hC0;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;
	localparam logic [7:0] CAP_RESET = 8'd255;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LENGTH = 3'd1,
		PH_BODY   = 3'd2,
		PH_TAIL   = 3'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_SHORT    = 4'd1,
		ST_RESPONSE = 4'd2,
		ST_OPCODE   = 4'd3,
		ST_COUNT    = 4'd4,
		ST_POINTER  = 4'd5,
		ST_OVERRUN  = 4'd6,
		ST_UNTERM   = 4'd7,
		ST_TRUNC    = 4'd8,
		ST_OVERSIZE = 4'd9
	} status_t;

	typedef struct packed {
		logic [15:0] byte_position;
		phase_t      parse_phase;
		logic [5:0]  label_bytes_left;
		logic [7:0]  name_length;
		logic [15:0] count_register;
		logic [15:0] terminator_position;
		status_t     failure_code;
	} parse_state_t;

	localparam parse_state_t PARSE_STATE_RESET = '{
		byte_position: 16'd0,
		parse_phase: PH_HEADER,
		label_bytes_left: 6'd0,
		name_length: 8'd0,
		count_register: 16'd0,
		terminator_position: 16'd0,
		failure_code: ST_OK
	};

	typedef struct packed {
		logic        char_strobe;
		logic [7:0]  name_char;
		logic        verdict_strobe;
		logic        query_valid;
		status_t     status_code;
		logic [15:0] question_end;
		logic [15:0] question_count;
	} parse_result_t;

	// LDH plus underscore pass through, all else becomes '?'
	function automatic logic [7:0] clean_octet(input logic [7:0] b);
		logic ok;
		ok = (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2D, 8'h5F});
		return ok ? b : CHAR_QMARK;
	endfunction

endpackage

[sv/dqqp_step.sv]
// Next-state and result logic for one datagram octet.
module dqqp_step import dqqp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic [7:0]    max_name_chars,
	output parse_state_t  nxt,
	output parse_result_t res,
	output logic          has_result
);

	parse_state_t upd;
	logic [15:0] pos;
	logic [15:0] new_count;
	logic        emit;
	logic [7:0]  ch;
	status_t     st;
	logic [15:0] qend;

	always_comb begin
		upd = cur;
		emit = 1'b0;
		ch = 8'd0;
		pos = cur.byte_position;
		new_count = {cur.count_register[15:8], data_byte};
		if (pos >= MAX_POS) begin
			upd.failure_code = ST_OVERSIZE;
		end else begin
			upd.byte_position = pos + 16'd1;
			if (cur.parse_phase == PH_HEADER) begin
				if (pos == HDR_FLAGS_POS && cur.failure_code == ST_OK) begin
					if ((data_byte & QR_MASK) != 8'd0)
						upd.failure_code = ST_RESPONSE;
					else if ((data_byte[6:3] & OPCODE_MASK) != 4'd0)
						upd.failure_code = ST_OPCODE;
				end
				if (pos == HDR_QDCNT_HI_POS)
					upd.count_register = {data_byte, cur.count_register[7:0]};
				if (pos == HDR_QDCNT_LO_POS) begin
					upd.count_register = new_count;
					if (cur.failure_code == ST_OK && new_count != 16'd1)
						upd.failure_code = ST_COUNT;
				end
				if (pos == HDR_LAST_POS)
					upd.parse_phase = PH_LENGTH;
			end else if (cur.failure_code == ST_OK) begin
				if (cur.parse_phase == PH_LENGTH) begin
					if (data_byte == 8'd0) begin
						upd.terminator_position = pos + 16'd1;
						upd.parse_phase = PH_TAIL;
					end else if ((data_byte & PTR_MASK) != 8'd0) begin
						upd.failure_code = ST_POINTER;
					end else begin
						upd.label_bytes_left = data_byte[5:0];
						upd.parse_phase = PH_BODY;
						if (cur.name_length != 8'd0 && cur.name_length < max_name_chars) begin
							emit = 1'b1;
							ch = CHAR_DOT;
							upd.name_length = cur.name_length + 8'd1;
						end
					end
				end else if (cur.parse_phase == PH_BODY) begin
					if (cur.name_length < max_name_chars) begin
						emit = 1'b1;
						ch = clean_octet(data_byte);
						upd.name_length = cur.name_length + 8'd1;
					end
					upd.label_bytes_left = cur.label_bytes_left - 6'd1;
					if (cur.label_bytes_left == 6'd1)
						upd.parse_phase = PH_LENGTH;
				end
			end
		end
	end

	// verdict on the final octet
	always_comb begin
		qend = 16'd0;
		if (upd.failure_code == ST_OVERSIZE)
			st = ST_OVERSIZE;
		else if (upd.byte_position < HDR_BYTES)
			st = ST_SHORT;
		else if (upd.failure_code != ST_OK)
			st = upd.failure_code;
		else if (upd.parse_phase == PH_LENGTH)
			st = ST_UNTERM;
		else if (upd.parse_phase == PH_BODY)
			st = ST_OVERRUN;
		else if (({1'b0, upd.terminator_position} + 17'd4) > {1'b0, upd.byte_position})
			st = ST_TRUNC;
		else begin
			st = ST_OK;
			qend = upd.terminator_position + 16'd4;
		end
	end

	always_comb begin
		res.char_strobe = emit;
		res.name_char = ch;
		res.verdict_strobe = last_byte;
		res.query_valid = last_byte && (st == ST_OK);
		res.status_code = last_byte ? st : ST_OK;
		res.question_end = last_byte ? qend : 16'd0;
		if (!last_byte || st inside {ST_SHORT, ST_RESPONSE, ST_OPCODE})
			res.question_count = 16'd0;
		else
			res.question_count = upd.count_register;
		has_result = emit || last_byte;
		nxt = last_byte ? PARSE_STATE_RESET : upd;
	end

endmodule

[sv/dns_query_question_parser_top.sv]
// Top level of the DNS query question parser: input stage, parse state and result register.
// Each octet is registered in the input stage; its result is then registered in the result register.
// Throughput: one octet per cycle while results are taken.
// Octets that cause no character and are not last give no result.
// Reset (arst_n low) clears parse state and the valid flags of both stages, and sets the name cap to 255.
module dns_query_question_parser_top import dqqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        char_strobe,
	output logic [7:0]  name_char,
	output logic        verdict_strobe,
	output logic        query_valid,
	output logic [3:0]  status_code,
	output logic [15:0] question_end,
	output logic [15:0] question_count
);

	logic          vld_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic [7:0]    max_name_chars_q;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;
	parse_result_t res_q;
	logic          out_vld_q;
	logic          has_result;
	logic          advance;

	dqqp_step u_step (
		.cur           (state_q),
		.data_byte     (byte_s1),
		.last_byte     (last_s1),
		.max_name_chars(max_name_chars_q),
		.nxt           (state_nxt),
		.res           (res_nxt),
		.has_result    (has_result)
	);

	assign advance = vld_s1 && (!out_vld_q || out_ready || !has_result);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_chars_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			max_name_chars_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && has_result) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_vld_q;
	assign char_strobe = res_q.char_strobe;
	assign name_char = res_q.name_char;
	assign verdict_strobe = res_q.verdict_strobe;
	assign query_valid = res_q.query_valid;
	assign status_code = res_q.status_code;
	assign question_end = res_q.question_end;
	assign question_count = res_q.question_count;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the DNS query question parser: directed and random datagrams.
`timescale 1ns / 100ps

module tb_top import dqqp_pkg::*; ();

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_OCTETS = 100;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		logic [7:0] octet;
		logic       lst;
	} octet_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        char_strobe;
	logic [7:0]  name_char;
	logic        verdict_strobe;
	logic        query_valid;
	logic [3:0]  status_code;
	logic [15:0] question_end;
	logic [15:0] question_count;

	octet_item_t   tx_octets[$];
	parse_result_t want_results[$];
	logic [7:0]    dg[$];

	// flow control
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_go = 1'b0;
	logic        hold_on = 1'b0;
	logic        in_took = 1'b0;

	// bookkeeping
	int octets_queued = 0;
	int octets_taken = 0;
	int results_taken = 0;
	int dgram_count = 0;
	int mismatches = 0;
	int quiet = 0;
	int status_seen[10];

	// predictor state
	logic [7:0]  name_cap;
	int unsigned seen_octets;
	phase_t      walk_phase;
	logic [5:0]  label_left;
	logic [7:0]  name_len;
	logic [15:0] qdcount;
	int unsigned root_end;
	status_t     first_fault;

	dns_query_question_parser_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.char_strobe    (char_strobe),
		.name_char      (name_char),
		.verdict_strobe (verdict_strobe),
		.query_valid    (query_valid),
		.status_code    (status_code),
		.question_end   (question_end),
		.question_count (question_count)
	);

	always #5 clk = ~clk;

	function automatic void clear_walk();
		seen_octets = 0;
		walk_phase = PH_HEADER;
		label_left = '0;
		name_len = '0;
		qdcount = '0;
		root_end = 0;
		first_fault = ST_OK;
	endfunction

	function automatic logic [7:0] host_octet(input logic [7:0] b);
		bit ok;
		ok = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F;
		return ok ? b : CHAR_QMARK;
	endfunction

	// advance the parse by one octet; returns 1 when a result is due
	function automatic bit parse_octet(input logic [7:0] b, input logic lst,
			output parse_result_t r);
		int unsigned p;
		status_t st;
		bit emit;
		logic [7:0] ch;
		emit = 1'b0;
		ch = '0;
		r = '0;
		st = ST_OK;
		if (seen_octets >= MAX_DATAGRAM_BYTES) begin
			first_fault = ST_OVERSIZE;
		end else begin
			p = seen_octets;
			seen_octets = p + 1;
			if (walk_phase == PH_HEADER) begin
				if (p == HDR_FLAGS_POS && first_fault == ST_OK) begin
					if ((b & QR_MASK) != 0)
						first_fault = ST_RESPONSE;
					else if (((b >> 3) & OPCODE_MASK) != 0)
						first_fault = ST_OPCODE;
				end
				if (p == HDR_QDCNT_HI_POS)
					qdcount[15:8] = b;
				if (p == HDR_QDCNT_LO_POS) begin
					qdcount[7:0] = b;
					if (first_fault == ST_OK && qdcount != 16'd1)
						first_fault = ST_COUNT;
				end
				if (p == HDR_LAST_POS)
					walk_phase = PH_LENGTH;
			end else if (first_fault == ST_OK) begin
				case (walk_phase)
					PH_LENGTH: begin
						if (b == 8'd0) begin
							root_end = seen_octets;
							walk_phase = PH_TAIL;
						end else if ((b & PTR_MASK) != 0) begin
							first_fault = ST_POINTER;
						end else begin
							label_left = b[5:0];
							walk_phase = PH_BODY;
							if (name_len > 0 && name_len < name_cap) begin
								emit = 1'b1;
								ch = CHAR_DOT;
								name_len++;
							end
						end
					end
					PH_BODY: begin
						if (name_len < name_cap) begin
							emit = 1'b1;
							ch = host_octet(b);
							name_len++;
						end
						label_left = label_left - 6'd1;
						if (label_left == 0)
							walk_phase = PH_LENGTH;
					end
					default: ;
				endcase
			end
		end
		if (emit) begin
			r.char_strobe = 1'b1;
			r.name_char = ch;
		end
		if (lst) begin
			if (first_fault == ST_OVERSIZE)
				st = ST_OVERSIZE;
			else if (seen_octets < HDR_BYTES)
				st = ST_SHORT;
			else if (first_fault != ST_OK)
				st = first_fault;
			else if (walk_phase == PH_LENGTH)
				st = ST_UNTERM;
			else if (walk_phase == PH_BODY)
				st = ST_OVERRUN;
			else if (root_end + 4 > seen_octets)
				st = ST_TRUNC;
			else
				st = ST_OK;
			r.verdict_strobe = 1'b1;
			r.query_valid = (st == ST_OK);
			r.status_code = st;
			r.question_end = (st == ST_OK) ? 16'(root_end + 4) : 16'd0;
			r.question_count = (st == ST_SHORT || st == ST_RESPONSE || st == ST_OPCODE) ?
				16'd0 : qdcount;
			clear_walk();
		end
		return emit || lst;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// driver: new payload at the falling edge once the previous transfer is done
	always @(negedge clk) begin : drive
		octet_item_t item;
		if (!in_valid || in_took) begin
			if (tx_octets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = tx_octets.pop_front();
				in_valid <= 1'b1;
				data_byte <= item.octet;
				last_byte <= item.lst;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
	end

	// monitor: predicts on input transfers, checks output transfers
	always @(posedge clk) begin : watch
		parse_result_t want;
		parse_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.char_strobe = char_strobe;
				got.name_char = name_char;
				got.verdict_strobe = verdict_strobe;
				got.query_valid = query_valid;
				got.status_code = status_t'(status_code);
				got.question_end = question_end;
				got.question_count = question_count;
				results_taken++;
				if (want_results.size() == 0) begin
					report_mismatch("result with none expected", 16'(got.name_char), 16'd0);
				end else begin
					want = want_results.pop_front();
					if (got.char_strobe !== want.char_strobe)
						report_mismatch("char_strobe", 16'(got.char_strobe),
							16'(want.char_strobe));
					if (got.name_char !== want.name_char)
						report_mismatch("name_char", 16'(got.name_char), 16'(want.name_char));
					if (got.verdict_strobe !== want.verdict_strobe)
						report_mismatch("verdict_strobe", 16'(got.verdict_strobe),
							16'(want.verdict_strobe));
					if (got.query_valid !== want.query_valid)
						report_mismatch("query_valid", 16'(got.query_valid),
							16'(want.query_valid));
					if (got.status_code !== want.status_code)
						report_mismatch("status_code", 16'(got.status_code),
							16'(want.status_code));
					if (got.question_end !== want.question_end)
						report_mismatch("question_end", got.question_end, want.question_end);
					if (got.question_count !== want.question_count)
						report_mismatch("question_count", got.question_count,
							want.question_count);
					if (want.verdict_strobe)
						status_seen[want.status_code]++;
				end
			end
			if (in_valid && in_ready) begin
				if (parse_octet(data_byte, last_byte, want))
					want_results.push_back(want);
				octets_taken++;
			end
			in_took <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t no transfer for %0d cycles", $realtime, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic set_name_cap(input logic [7:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		name_cap = v;
	endtask

	task automatic drain_and_rest();
		while (!(octets_taken == octets_queued && want_results.size() == 0))
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] label_octet();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			return 8'(8'h61 + $urandom_range(25));
		else if (r < 50)
			return 8'(8'h41 + $urandom_range(25));
		else if (r < 65)
			return 8'(8'h30 + $urandom_range(9));
		else if (r < 72)
			return 8'h2D;
		else if (r < 78)
			return 8'h5F;
		return 8'($urandom);
	endfunction

	function automatic int unsigned label_len();
		return ($urandom_range(19) == 0) ? $urandom_range(63, 1) : $urandom_range(10, 1);
	endfunction

	task automatic put_header(input logic [7:0] flags, input logic [15:0] qd);
		dg.delete();
		dg.push_back(8'($urandom));
		dg.push_back(8'($urandom));
		dg.push_back(flags);
		dg.push_back(8'($urandom));
		dg.push_back(qd[15:8]);
		dg.push_back(qd[7:0]);
		repeat (6) dg.push_back(8'($urandom));
	endtask

	task automatic put_label(input int unsigned len);
		dg.push_back(8'(len));
		repeat (len) dg.push_back(label_octet());
	endtask

	task automatic put_name(input int unsigned labels);
		repeat (labels) put_label(label_len());
		dg.push_back(8'h00);
	endtask

	task automatic put_tail(input int unsigned extra);
		repeat (4 + extra) dg.push_back(8'($urandom));
	endtask

	task automatic send_dg();
		octet_item_t item;
		foreach (dg[i]) begin
			item.octet = dg[i];
			item.lst = (i == dg.size() - 1);
			tx_octets.push_back(item);
			octets_queued++;
		end
		dgram_count++;
	endtask

	task automatic random_datagram();
		int unsigned kind;
		int unsigned keep;
		logic [7:0] flags;
		logic [15:0] qd;
		kind = $urandom_range(99);
		if (kind < 8) begin
			dg.delete();
			repeat ($urandom_range(40, 1)) dg.push_back(8'($urandom));
		end else begin
			flags = {5'b00000, 3'($urandom)};
			qd = 16'd1;
			if (kind < 14)
				flags = flags | QR_MASK | 8'($urandom);
			else if (kind < 20)
				flags[6:3] = 4'($urandom_range(15, 1));
			else if (kind < 26) begin
				qd = 16'($urandom);
				if (qd == 16'd1)
					qd = 16'd0;
			end
			put_header(flags, qd);
			if (kind >= 26 && kind < 32) begin
				repeat ($urandom_range(2)) put_label(label_len());
				dg.push_back(8'($urandom_range(255, 64)));
				dg.push_back(8'($urandom));
			end else begin
				put_name($urandom_range(4));
				put_tail($urandom_range(3));
				if (kind >= 32 && kind < 50) begin
					if (dg.size() > 7 && $urandom_range(1))
						keep = dg.size() - $urandom_range(6, 1);
					else
						keep = $urandom_range(dg.size() - 1, 1);
					while (dg.size() > keep)
						void'(dg.pop_back());
				end
			end
		end
		send_dg();
	endtask

	initial begin : stimulus
		int caps[8];
		int unsigned cap;
		int unsigned target;
		caps = '{1, 0, 255, 12, -1, 2, -1, 255};
		name_cap = CAP_RESET;
		clear_walk();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset cap, no flow control
		dg.delete();
		dg.push_back(8'hFF);
		send_dg();
		put_header(8'h80, 16'd1);
		void'(dg.pop_back());
		send_dg();
		put_header(8'h00, 16'd1);
		send_dg();
		put_header(8'h07, 16'd1);
		dg.push_back(8'h00);
		put_tail(0);
		send_dg();
		put_header(8'h01, 16'd1);
		put_name(3);
		put_tail(3);
		send_dg();
		put_header(8'h80, 16'd0);
		put_name(1);
		put_tail(0);
		send_dg();
		put_header(8'h08, 16'd1);
		put_name(1);
		put_tail(0);
		send_dg();
		put_header(8'h7F, 16'd1);
		put_name(2);
		put_tail(0);
		send_dg();
		put_header(8'h00, 16'hFFFF);
		put_name(1);
		put_tail(0);
		send_dg();
		put_header(8'h00, 16'd1);
		put_label(3);
		dg.push_back(8'hC0);
		dg.push_back(8'h0C);
		send_dg();
		put_header(8'h00, 16'd1);
		dg.push_back(8'h40);
		put_tail(0);
		send_dg();
		put_header(8'h00, 16'd1);
		dg.push_back(8'h05);
		dg.push_back(8'h61);
		dg.push_back(8'h62);
		send_dg();
		put_header(8'h00, 16'd1);
		put_label(3);
		dg.push_back(8'h07);
		send_dg();
		put_header(8'h00, 16'd1);
		put_label(3);
		send_dg();
		put_header(8'h00, 16'd1);
		put_label(2);
		dg.push_back(8'h00);
		repeat (3) dg.push_back(8'($urandom));
		send_dg();
		put_header(8'h00, 16'd1);
		repeat (5) put_label(63);
		dg.push_back(8'h00);
		put_tail(1);
		send_dg();
		put_header(8'h00, 16'd1);
		put_name(2);
		put_tail(0);
		send_dg();
		drain_and_rest();

		// random phases: name cap and flow control vary
		foreach (caps[i]) begin
			cap = (caps[i] < 0) ? $urandom_range(255, 1) : caps[i];
			set_name_cap(8'(cap));
			case (i % 4)
				0: begin send_idle_pct = 82; stall_pct = 0; end
				1: begin send_idle_pct = 0; stall_pct = 82; end
				2: begin send_idle_pct = 11; stall_pct = 11; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			if (i == 3)
				hold_go = 1'b1;
			target = octets_queued + PHASE_OCTETS;
			while (octets_queued < target)
				random_datagram();
			drain_and_rest();
		end

		$display("Sent %0d datagrams, %0d octets, under 9 cap and flow settings; %0d results",
			dgram_count, octets_taken, results_taken);
		$display("Verdicts by status code 0 to 9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5], status_seen[6], status_seen[7], status_seen[8], status_seen[9]);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
